/* hw/rtl/wfd_pkg.sv */
// Package for the WebSocket frame decoder: transaction types, parse phases
// and header constants; every module of the block imports it.
// Depends on nothing.
package wfd_pkg;

  // One received byte of the frame stream.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       buffer_end;
  } wfd_in_t;

  // One decoded result.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_data;
    logic       frame_end;
    logic       fin;
    logic [3:0] frame_opcode;
    logic       truncated;
  } wfd_out_t;

  // Parse phases, one-hot.
  typedef enum logic [4:0] {
    PH_HDR0    = 5'b00001,
    PH_HDR1    = 5'b00010,
    PH_EXTLEN  = 5'b00100,
    PH_KEY     = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } wfd_phase_t;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

endpackage

/* hw/rtl/wfd_in_reg.sv */
// Input register of the WebSocket frame decoder: holds one received byte
// until the parser steps on it. Depends on wfd_pkg.
module wfd_in_reg
  import wfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  wfd_in_t item,
  input  logic    take,
  output logic    q_valid,
  output wfd_in_t q_item
);

  // The register can load whenever it is empty or its content leaves now.
  assign item_ready = !q_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (item_ready) begin
      q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      q_item <= item;
    end
  end

endmodule

/* hw/rtl/wfd_parser.sv */
// Frame parser of the WebSocket frame decoder: parse state registers and the
// single-pass step logic that turns one byte into at most one result.
// Depends on wfd_pkg.
module wfd_parser
  import wfd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     step,
  input  wfd_in_t  item,
  output logic     emit,
  output wfd_out_t res
);

  wfd_phase_t  phase, phase_next;
  logic        fin_flag, fin_flag_next;
  logic [3:0]  opcode, opcode_next;
  logic        masked, masked_next;
  logic [3:0]  hdr_left, hdr_left_next;
  logic [63:0] payload_left, payload_left_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  key_pos, key_pos_next;

  logic [7:0]  b;
  logic [6:0]  len7;
  logic [7:0]  key_byte;
  logic        data;
  logic        frame_end;
  logic        trunc;
  logic [7:0]  obyte;

  assign b    = item.in_byte;
  assign len7 = b[6:0];

  always_comb begin
    case (key_pos)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next        = phase;
    fin_flag_next     = fin_flag;
    opcode_next       = opcode;
    masked_next       = masked;
    hdr_left_next     = hdr_left;
    payload_left_next = payload_left;
    mask_key_next     = mask_key;
    key_pos_next      = key_pos;
    data              = 1'b0;
    frame_end         = 1'b0;
    obyte             = 8'd0;

    unique case (phase)
      PH_HDR1: begin
        masked_next       = b[7];
        payload_left_next = 64'd0;
        if (len7 == LEN_EXT16) begin
          phase_next    = PH_EXTLEN;
          hdr_left_next = EXT16_BYTES;
        end else if (len7 == LEN_EXT64) begin
          phase_next    = PH_EXTLEN;
          hdr_left_next = EXT64_BYTES;
        end else begin
          payload_left_next = {57'd0, len7};
          if (b[7]) begin
            phase_next    = PH_KEY;
            hdr_left_next = KEY_BYTES;
          end else begin
            key_pos_next = 2'd0;
            if (len7 == 7'd0) begin
              phase_next = PH_HDR0;
              frame_end  = 1'b1;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end
        end
      end
      PH_EXTLEN: begin
        payload_left_next = {payload_left[55:0], b};
        hdr_left_next     = hdr_left - 4'd1;
        if (hdr_left_next == 4'd0) begin
          if (masked) begin
            phase_next    = PH_KEY;
            hdr_left_next = KEY_BYTES;
          end else begin
            key_pos_next = 2'd0;
            if (payload_left_next == 64'd0) begin
              phase_next = PH_HDR0;
              frame_end  = 1'b1;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end
        end
      end
      PH_KEY: begin
        mask_key_next = {mask_key[23:0], b};
        hdr_left_next = hdr_left - 4'd1;
        if (hdr_left_next == 4'd0) begin
          key_pos_next = 2'd0;
          if (payload_left == 64'd0) begin
            phase_next = PH_HDR0;
            frame_end  = 1'b1;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        obyte             = masked ? (b ^ key_byte) : b;
        key_pos_next      = key_pos + 2'd1;
        payload_left_next = payload_left - 64'd1;
        data              = 1'b1;
        if (payload_left_next == 64'd0) begin
          frame_end  = 1'b1;
          phase_next = PH_HDR0;
        end
      end
      default: begin
        // First header byte, and any phase code that means nothing.
        fin_flag_next     = b[7];
        opcode_next       = b[3:0];
        masked_next       = 1'b0;
        payload_left_next = 64'd0;
        mask_key_next     = 32'd0;
        key_pos_next      = 2'd0;
        hdr_left_next     = 4'd0;
        phase_next        = PH_HDR1;
      end
    endcase

    // The buffer ended before the frame did: report and drop the frame.
    trunc = item.buffer_end && !frame_end;
    if (trunc) begin
      phase_next        = PH_HDR0;
      hdr_left_next     = 4'd0;
      payload_left_next = 64'd0;
      key_pos_next      = 2'd0;
    end
  end

  assign emit = data || frame_end || trunc;

  always_comb begin
    res.out_byte     = obyte;
    res.has_data     = data;
    res.frame_end    = frame_end;
    res.fin          = fin_flag_next;
    res.frame_opcode = opcode_next;
    res.truncated    = trunc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR0;
      fin_flag     <= 1'b0;
      opcode       <= 4'd0;
      masked       <= 1'b0;
      hdr_left     <= 4'd0;
      payload_left <= 64'd0;
      mask_key     <= 32'd0;
      key_pos      <= 2'd0;
    end else if (step) begin
      phase        <= phase_next;
      fin_flag     <= fin_flag_next;
      opcode       <= opcode_next;
      masked       <= masked_next;
      hdr_left     <= hdr_left_next;
      payload_left <= payload_left_next;
      mask_key     <= mask_key_next;
      key_pos      <= key_pos_next;
    end
  end

`ifndef SYNTHESIS
  // A payload byte always produces a result.
  a_payload_emits: assert property (@(posedge clk) disable iff (rst)
    step && (phase == PH_PAYLOAD) |-> emit && res.has_data)
    else $error("payload byte gave no data result");

  // Data results come only from the payload phase.
  a_data_in_payload: assert property (@(posedge clk) disable iff (rst)
    step && res.has_data |-> (phase == PH_PAYLOAD))
    else $error("data result outside payload phase");

  // After a frame ends or is dropped, the next byte is a first header byte.
  a_back_to_idle: assert property (@(posedge clk) disable iff (rst)
    step && (res.frame_end || res.truncated) |=> (phase == PH_HDR0))
    else $error("parser did not return to idle after frame end");
`endif

endmodule

/* hw/rtl/wfd_out_reg.sv */
// Result register of the WebSocket frame decoder: holds one result until
// the consumer takes it. Depends on wfd_pkg.
module wfd_out_reg
  import wfd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     load,
  input  wfd_out_t d,
  output logic     can_take,
  output logic     result_valid,
  input  logic     result_ready,
  output wfd_out_t result
);

  assign can_take = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (can_take) begin
      result_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_take) begin
      result <= d;
    end
  end

endmodule

/* hw/rtl/websocket_frame_decoder_top.sv */
// Top level of the WebSocket frame decoder: input register, frame parser and
// result register. Depends on wfd_pkg, wfd_in_reg, wfd_parser, wfd_out_reg.
//
//   Channel   Direction   Handshake                    Payload
//   item      in          item_valid / item_ready      wfd_in_t  (byte, buffer end)
//   result    out         result_valid / result_ready  wfd_out_t (byte, flags, header)
//
// The block takes one byte per clock cycle for as long as results are taken.
// A byte is registered in the input register on acceptance, parsed once the result
// register has room, and its result, if any, is registered in the result register.
// The throughput limit is the parser step itself: one byte per cycle, as long as the
// result register has room.
// Reset is synchronous and clears the parse state at once; no clearing pass.
// When the result register is held, one further byte still enters the input
// register; the parser stalls until the held result is taken.
module websocket_frame_decoder_top
  import wfd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_ready,
  input  wfd_in_t  item,
  output logic     result_valid,
  input  logic     result_ready,
  output wfd_out_t result
);

  logic     q_valid;
  wfd_in_t  q_item;
  logic     step;
  logic     emit;
  wfd_out_t res;
  logic     can_take;

  // The parser steps on a registered byte whenever the result register has
  // room, so a byte never has to wait for a decision on whether it emits.
  assign step = q_valid && can_take;

  wfd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .take       (step),
    .q_valid    (q_valid),
    .q_item     (q_item)
  );

  wfd_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (q_item),
    .emit (emit),
    .res  (res)
  );

  wfd_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (step && emit),
    .d            (res),
    .can_take     (can_take),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

`ifndef SYNTHESIS
  // A stalled input side means a byte is already waiting in the input register.
  a_stall_means_full: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> q_valid)
    else $error("input stalled with empty input register");

  // A truncated result never also closes the frame normally.
  a_trunc_not_end: assert property (@(posedge clk) disable iff (rst)
    step && emit && res.truncated |-> !res.frame_end)
    else $error("result marked both truncated and frame end");

  // Every parser step that emits lands in the result register.
  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    step && emit |=> result_valid)
    else $error("emitted result was lost");
`endif

endmodule

/* tb/tb_websocket_frame_decoder_top.sv */
// Testbench for websocket_frame_decoder_top: drives random and directed frame
// byte streams and checks every decoded result against a built-in predictor.
// Depends on wfd_pkg and the decoder RTL under hw/rtl.
module tb_websocket_frame_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wfd_pkg::*;

  // Scoreboard: tracks the parse state of the decoder byte by byte and keeps
  // the decoded results that the block still owes us, oldest first.
  class ws_decode_scoreboard;
    wfd_phase_t  phase;
    logic        fin_bit;
    logic [3:0]  opcode;
    logic        masked;
    logic [3:0]  hdr_left;
    logic [63:0] pay_left;
    logic [31:0] mask_key;
    logic [1:0]  key_pos;
    wfd_out_t    decoded_q[$];
    int          errors;

    function new();
      phase    = PH_HDR0;
      fin_bit  = 1'b0;
      opcode   = '0;
      masked   = 1'b0;
      hdr_left = '0;
      pay_left = '0;
      mask_key = '0;
      key_pos  = '0;
      errors   = 0;
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction

    // Key and length are both known. Returns 1 when an empty frame just closed.
    function bit key_done();
      key_pos = '0;
      if (pay_left == 64'd0) begin
        phase = PH_HDR0;
        return 1'b1;
      end
      phase = PH_PAYLOAD;
      return 1'b0;
    endfunction

    // Length is known; a masking key may still follow.
    function bit length_done();
      if (masked) begin
        phase    = PH_KEY;
        hdr_left = KEY_BYTES;
        return 1'b0;
      end
      return key_done();
    endfunction

    // Works out the decoded result, if any, of one accepted input transaction.
    function void accept_byte(wfd_in_t it);
      logic [7:0] b;
      logic [7:0] ob;
      logic       emit;
      logic       data;
      logic       closes;
      logic       trunc;
      wfd_out_t   res;
      b      = it.in_byte;
      ob     = 8'h00;
      emit   = 1'b0;
      data   = 1'b0;
      closes = 1'b0;
      case (phase)
        PH_HDR1: begin
          masked   = b[7];
          pay_left = '0;
          if (b[6:0] == LEN_EXT16) begin
            phase    = PH_EXTLEN;
            hdr_left = EXT16_BYTES;
          end else if (b[6:0] == LEN_EXT64) begin
            phase    = PH_EXTLEN;
            hdr_left = EXT64_BYTES;
          end else begin
            pay_left = {57'd0, b[6:0]};
            closes   = length_done();
          end
        end
        PH_EXTLEN: begin
          pay_left = {pay_left[55:0], b};
          hdr_left = hdr_left - 4'd1;
          if (hdr_left == 4'd0) closes = length_done();
        end
        PH_KEY: begin
          mask_key = {mask_key[23:0], b};
          hdr_left = hdr_left - 4'd1;
          if (hdr_left == 4'd0) closes = key_done();
        end
        PH_PAYLOAD: begin
          ob = masked ? (b ^ mask_key[8 * (3 - int'(key_pos)) +: 8]) : b;
          key_pos  = key_pos + 2'd1;
          pay_left = pay_left - 64'd1;
          data     = 1'b1;
          emit     = 1'b1;
          if (pay_left == 64'd0) begin
            closes = 1'b1;
            phase  = PH_HDR0;
          end
        end
        default: begin
          fin_bit  = b[7];
          opcode   = b[3:0];
          masked   = 1'b0;
          pay_left = '0;
          mask_key = '0;
          key_pos  = '0;
          hdr_left = '0;
          phase    = PH_HDR1;
        end
      endcase
      if (closes) emit = 1'b1;
      trunc = it.buffer_end && !closes;
      if (trunc) begin
        emit     = 1'b1;
        phase    = PH_HDR0;
        hdr_left = '0;
        pay_left = '0;
        key_pos  = '0;
      end
      if (emit) begin
        res.out_byte     = ob;
        res.has_data     = data;
        res.frame_end    = closes;
        res.fin          = fin_bit;
        res.frame_opcode = opcode;
        res.truncated    = trunc;
        decoded_q.push_back(res);
      end
    endfunction

    function void compare_field(string name, logic [7:0] exp, logic [7:0] act);
      if (exp !== act) begin
        $display("%0t: field %s expected 0x%0h actual 0x%0h", $time, name, exp, act);
        errors++;
      end
    endfunction

    // Compares one accepted result transaction with the oldest expectation.
    function void check_decoded(wfd_out_t got);
      wfd_out_t exp;
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result expected none actual 0x%0h", $time, got);
        errors++;
        return;
      end
      exp = decoded_q.pop_front();
      compare_field("out_byte", exp.out_byte, got.out_byte);
      compare_field("has_data", 8'(exp.has_data), 8'(got.has_data));
      compare_field("frame_end", 8'(exp.frame_end), 8'(got.frame_end));
      compare_field("fin", 8'(exp.fin), 8'(got.fin));
      compare_field("frame_opcode", 8'(exp.frame_opcode), 8'(got.frame_opcode));
      compare_field("truncated", 8'(exp.truncated), 8'(got.truncated));
    endfunction
  endclass

  localparam int RANDOM_ITEMS = 1650;
  localparam int DRAIN_EVERY  = 500;
  localparam int IDLE_PCT     = 26;
  localparam int TAIL_CYCLES  = 20;

  logic     clk          = 1'b0;
  logic     rst          = 1'b1;
  logic     item_valid   = 1'b0;
  logic     item_ready;
  wfd_in_t  item         = '0;
  logic     result_valid;
  logic     result_ready = 1'b0;
  wfd_out_t result;

  // When set, neither side inserts idle cycles, so back-to-back traffic is seen.
  logic steady = 1'b0;
  int   n_sent = 0;

  ws_decode_scoreboard sb;

  // Directed bytes, written as {buffer_end, byte}.
  logic [8:0] directed_bytes [$] = '{
    // Empty unmasked text frame with FIN: one empty end marker.
    9'h081, 9'h000,
    // Empty masked frame with opcode 15: the marker comes after the key.
    9'h00F, 9'h080, 9'h0DE, 9'h0AD, 9'h0BE, 9'h0EF,
    // Masked two-byte binary frame: payload bytes are unmasked by the key.
    9'h082, 9'h082, 9'h0AA, 9'h055, 9'h0FF, 9'h000, 9'h0FF, 9'h000,
    // 16-bit extended length of one, completed on the buffer end byte.
    9'h088, 9'h07E, 9'h000, 9'h001, 9'h1FF,
    // Buffer ends on the first header byte.
    9'h100,
    // 64-bit extended length cut off while the length is still arriving.
    9'h089, 9'h0FF, 9'h080, 9'h100
  };

  websocket_frame_decoder_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check each accepted result transaction, then pick the next
  // ready value. Values read here are the ones that were present at the edge.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_decoded(result);
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Offers one input transaction and waits for it to be taken. Idle cycles are
  // inserted ahead of it at random unless the steady window is open.
  task automatic send_byte(input logic [7:0] b, input logic be);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{in_byte: b, buffer_end: be};
    do @(posedge clk); while (!item_ready);
    sb.accept_byte(item);
    n_sent++;
    steady = (n_sent >= 700) && (n_sent < 1000);
  endtask

  // Holds the input side off until every expected result has been taken.
  task automatic drain_results();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Builds one random frame and sends it. Most frames are well formed; some
  // are cut short by the buffer end, and a few declare a huge length (top bit
  // of the length field set) that is never reached and always ends truncated.
  task automatic send_frame();
    logic [7:0] fbytes [$];
    logic       masked;
    logic       huge;
    int         kind;
    int         plen;
    int         cut;
    masked = 1'($urandom_range(0, 1));
    huge   = 1'b0;
    kind   = $urandom_range(0, 99);
    fbytes.push_back(8'($urandom));
    if (kind < 62) begin
      plen = (kind < 2) ? 125 : $urandom_range(0, 20);
      fbytes.push_back({masked, 7'(plen)});
    end else if (kind < 82) begin
      plen = ($urandom_range(0, 7) == 0) ? $urandom_range(126, 300) : $urandom_range(0, 40);
      fbytes.push_back({masked, LEN_EXT16});
      fbytes.push_back(8'(plen >> 8));
      fbytes.push_back(8'(plen));
    end else if (kind < 92) begin
      plen = $urandom_range(0, 40);
      fbytes.push_back({masked, LEN_EXT64});
      repeat (7) fbytes.push_back(8'h00);
      fbytes.push_back(8'(plen));
    end else begin
      huge = 1'b1;
      plen = $urandom_range(0, 6);
      if (kind < 96) begin
        fbytes.push_back({masked, LEN_EXT16});
        fbytes.push_back(8'($urandom) | 8'h80);
        fbytes.push_back(8'($urandom));
      end else begin
        fbytes.push_back({masked, LEN_EXT64});
        fbytes.push_back(8'($urandom) | 8'h80);
        repeat (7) fbytes.push_back(8'($urandom));
      end
    end
    if (masked) repeat (4) fbytes.push_back(8'($urandom));
    repeat (plen) fbytes.push_back(8'($urandom));

    if (huge) cut = fbytes.size() - 1;
    else if ($urandom_range(0, 9) == 0) cut = $urandom_range(0, fbytes.size() - 1);
    else if ($urandom_range(0, 9) == 0) cut = fbytes.size() - 1;
    else cut = -1;

    foreach (fbytes[i]) begin
      send_byte(fbytes[i], i == cut);
      if (i == cut) break;
    end
  endtask

  // Main stimulus: reset, the directed frames, then random traffic with a few
  // full drains on the way, and finally wait for the block to go quiet.
  initial begin
    int next_drain;
    int n;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_bytes[i]) send_byte(directed_bytes[i][7:0], directed_bytes[i][8]);
    drain_results();

    next_drain = n_sent + DRAIN_EVERY;
    while (n_sent < RANDOM_ITEMS + directed_bytes.size()) begin
      if ($urandom_range(0, 99) < 6) begin
        // Line noise: random bytes, closed by a buffer end so the parser is
        // back at the first header byte afterwards.
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++) begin
          send_byte(8'($urandom), (k == n - 1) || ($urandom_range(0, 3) == 0));
        end
      end else begin
        send_frame();
      end
      if (n_sent >= next_drain) begin
        drain_results();
        next_drain = n_sent + DRAIN_EVERY;
      end
    end

    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // A late extra result from the block would still be caught here.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
